// File: hw/rtl/voxel_column_run_length_encoder_assert.svh
// Assertion helpers shared by the encoder modules.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef VOXEL_COLUMN_RUN_LENGTH_ENCODER_ASSERT_SVH
`define VOXEL_COLUMN_RUN_LENGTH_ENCODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VCRLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define VCRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/vcrle_pkg.sv
`default_nettype none

package vcrle_pkg;

  // Column height limits and the configuration register
  localparam int unsigned MAX_HEIGHT   = 256;
  localparam int unsigned MAX_SEGMENTS = 65536;
  localparam int unsigned CFG_W        = 9;
  localparam int unsigned POS_W        = $clog2(MAX_HEIGHT + 1);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(32);

  // Field widths
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned FACES_W  = 6;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned SEGNUM_W = 16;
  localparam int unsigned COLNUM_W = 16;
  localparam int unsigned COLSEG_W = 9;

  // Segment counter saturates at the smaller of the two limits
  localparam int unsigned SEG_LIMIT =
    ((MAX_SEGMENTS - 1) > 65535) ? 65535 : (MAX_SEGMENTS - 1);

  // Stream payload widths
  localparam int unsigned IN_W  = 16;
  localparam int unsigned OUT_W = 80;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [COLSEG_W-1:0] col_segs;
    logic [SEGNUM_W-1:0] col_first;
    logic                col_end;
    logic [COLNUM_W-1:0] col_num;
    logic [SEGNUM_W-1:0] seg_num;
    logic [LEN_W-1:0]    length;
    logic [FACES_W-1:0]  faces;
    logic [COLOR_W-1:0]  color;
  } seg_t;

  // Up to two segments produced by one voxel, d0 ahead of d1
  typedef struct packed {
    logic v0;
    logic v1;
    seg_t d0;
    seg_t d1;
  } push_t;

endpackage

`default_nettype wire

// File: hw/rtl/vcrle_seg_queue.sv
`default_nettype none

module vcrle_seg_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire vcrle_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output vcrle_pkg::seg_t     out_seg
);
  import vcrle_pkg::*;

  seg_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QCNT_W-1:0] n_push;
  logic              pop;
  seg_t              first_seg;

  // Keep space for a two-segment voxel at all times
  assign room      = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_seg   = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Compact the pushes so the lone segment lands at the write pointer
  assign n_push    = QCNT_W'(push.v0) + QCNT_W'(push.v1);
  assign first_seg = push.v0 ? push.d0 : push.d1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_push);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + n_push - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store segment data
  always_ff @(posedge clk) begin
    if (push.v0 || push.v1) begin
      q_r[wr_ptr_r] <= first_seg;
    end
    if (push.v0 && push.v1) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= push.d1;
    end
  end

`include "voxel_column_run_length_encoder_assert.svh"

  `VCRLE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH), "queue count overflow")
  `VCRLE_ASSERT_NOW(a_push_room, push.v0 || push.v1, room, "segment pushed without room")
  `VCRLE_ASSERT_NEXT(a_pop_only, pop && !push.v0 && !push.v1, cnt_r == $past(cnt_r) - QCNT_W'(1), "pop did not drain one entry")

endmodule

`default_nettype wire

// File: hw/rtl/voxel_column_run_length_encoder.sv
`default_nettype none

// Run-length encoder for voxel columns. Voxels arrive on in_tdata one per
// transfer, each column bottom to top with column_height voxels (0 acts as
// 1, values above 256 act as 256). Every run of equal color and face mask
// leaves as one 80-bit segment on out_tdata; out_tlast marks a column's last
// segment, which also carries the column's first segment number and segment
// count (both zero on other segments). A column that is one empty run sends
// nothing. The block takes one voxel per cycle while in_tready is high: a
// voxel is encoded in the cycle it is accepted and its segments go into a
// four-entry result queue, from which they are offered in order on out_tvalid.
// in_tready drops while that queue holds more than two segments; with
// out_tready held high the queue never gets there, so the input side stalls
// only while the output side falls behind. cfg_ready is always high; write
// column_height only while the block is idle.
module voxel_column_run_length_encoder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // in_tdata: voxel_color[7:0], voxel_faces[13:8], zero[15:14]
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [vcrle_pkg::IN_W-1:0] in_tdata,
  // out_tdata: seg_color, seg_faces, seg_length, seg_number, column_number,
  //            column_first, column_segments (lowest bit up)
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [vcrle_pkg::OUT_W-1:0]     out_tdata,
  output logic                            out_tlast,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [vcrle_pkg::CFG_W-1:0] cfg_data
);
  import vcrle_pkg::*;

  logic [CFG_W-1:0]    height_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [COLOR_W-1:0]  run_color_r, run_color_nxt;
  logic [FACES_W-1:0]  run_faces_r, run_faces_nxt;
  logic [LEN_W-1:0]    run_count_r, run_count_nxt;
  logic [COLSEG_W-1:0] col_seg_r, col_seg_nxt;
  logic [SEGNUM_W-1:0] col_first_r, col_first_nxt;
  logic [SEGNUM_W-1:0] total_r, total_nxt;
  logic [COLNUM_W-1:0] col_cnt_r, col_cnt_nxt;

  logic [COLOR_W-1:0]  in_color;
  logic [FACES_W-1:0]  in_faces;
  logic [CFG_W-1:0]    height_eff;
  logic [POS_W-1:0]    pos_inc;
  logic                in_xfer;
  logic                col_start, run_break, col_done, emit_last;
  logic [SEGNUM_W-1:0] total_mid;
  push_t               push;
  logic                room;
  seg_t                out_seg;

  assign in_color  = in_tdata[COLOR_W-1:0];
  assign in_faces  = in_tdata[COLOR_W+FACES_W-1:COLOR_W];
  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = room;
  assign cfg_ready = 1'b1;

  // Clamp the configured height
  always_comb begin
    height_eff = height_r;
    if (height_r == '0) begin
      height_eff = CFG_W'(1);
    end else if (height_r > CFG_W'(MAX_HEIGHT)) begin
      height_eff = CFG_W'(MAX_HEIGHT);
    end
  end

  // Encode one voxel against the open run
  always_comb begin
    col_start = (pos_r == '0);
    run_break = !col_start && ((in_color != run_color_r) || (in_faces != run_faces_r));

    total_mid = total_r;
    if (run_break && (total_r < SEGNUM_W'(SEG_LIMIT))) begin
      total_mid = total_r + SEGNUM_W'(1);
    end

    col_seg_nxt   = col_start ? '0 : (run_break ? col_seg_r + COLSEG_W'(1) : col_seg_r);
    col_first_nxt = col_start ? total_r : col_first_r;

    if (col_start || run_break) begin
      run_color_nxt = in_color;
      run_faces_nxt = in_faces;
      run_count_nxt = LEN_W'(1);
    end else begin
      run_color_nxt = run_color_r;
      run_faces_nxt = run_faces_r;
      run_count_nxt = run_count_r + LEN_W'(1);
    end

    pos_inc   = pos_r + POS_W'(1);
    col_done  = (CFG_W'(pos_inc) >= height_eff);
    emit_last = col_done && !((col_seg_nxt == '0) && (run_color_nxt == '0));
    pos_nxt   = col_done ? '0 : pos_inc;

    total_nxt = total_mid;
    if (emit_last && (total_mid < SEGNUM_W'(SEG_LIMIT))) begin
      total_nxt = total_mid + SEGNUM_W'(1);
    end

    col_cnt_nxt = col_cnt_r;
    if (col_done && (col_cnt_r != '1)) begin
      col_cnt_nxt = col_cnt_r + COLNUM_W'(1);
    end
  end

  // Build the closed run and the column's final run
  always_comb begin
    push.v0          = in_xfer && run_break;
    push.d0.color    = run_color_r;
    push.d0.faces    = run_faces_r;
    push.d0.length   = run_count_r;
    push.d0.seg_num  = total_r;
    push.d0.col_num  = col_cnt_r;
    push.d0.col_end  = 1'b0;
    push.d0.col_first = '0;
    push.d0.col_segs = '0;

    push.v1          = in_xfer && emit_last;
    push.d1.color    = run_color_nxt;
    push.d1.faces    = run_faces_nxt;
    push.d1.length   = run_count_nxt;
    push.d1.seg_num  = total_mid;
    push.d1.col_num  = col_cnt_r;
    push.d1.col_end  = 1'b1;
    push.d1.col_first = col_first_nxt;
    push.d1.col_segs = col_seg_nxt + COLSEG_W'(1);
  end

  // Advance encoder state on each voxel transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r    <= HEIGHT_RESET;
      pos_r       <= '0;
      run_color_r <= '0;
      run_faces_r <= '0;
      run_count_r <= '0;
      col_seg_r   <= '0;
      col_first_r <= '0;
      total_r     <= '0;
      col_cnt_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        height_r <= cfg_data;
      end
      if (in_xfer) begin
        pos_r       <= pos_nxt;
        run_color_r <= run_color_nxt;
        run_faces_r <= run_faces_nxt;
        run_count_r <= run_count_nxt;
        col_seg_r   <= col_seg_nxt;
        col_first_r <= col_first_nxt;
        total_r     <= total_nxt;
        col_cnt_r   <= col_cnt_nxt;
      end
    end
  end

  vcrle_seg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_seg   (out_seg)
  );

  assign out_tdata = {out_seg.col_segs, out_seg.col_first, out_seg.col_num,
                      out_seg.seg_num, out_seg.length, out_seg.faces, out_seg.color};
  assign out_tlast = out_seg.col_end;

`include "voxel_column_run_length_encoder_assert.svh"

  `VCRLE_ASSERT_NOW(a_pos_bound, 1'b1, pos_r < POS_W'(MAX_HEIGHT),
                    "column position past maximum height")
  `VCRLE_ASSERT_NOW(a_seg_vs_pos, pos_r != '0, COLSEG_W'(col_seg_r) < COLSEG_W'(pos_r),
                    "more segments than voxels in column")
  `VCRLE_ASSERT_NEXT(a_total_mono, 1'b1, total_r >= $past(total_r),
                     "segment counter went backward")

endmodule

`default_nettype wire
